// ===== rtl/core/bitmap_page_allocator_macros.svh =====
// Assertion helpers for the page allocator
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

`define BPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/bpa_pkg.sv =====
package bpa_pkg;
    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 13;
    localparam int STAT_W  = 3;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISALIGNED = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE      = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO       = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [0:0] REG_MEM_BASE    = 1'b0;
    localparam logic [0:0] REG_TOTAL_PAGES = 1'b1;

    localparam logic [7:0] BYTE_FULL  = 8'hFF;
    localparam logic [7:0] BYTE_EMPTY = 8'h00;

    typedef struct packed {
        logic op;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0] addr;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] alloc_addr;
    } t_rsp;
endpackage

// ===== rtl/core/bpa_if.sv =====
interface bpa_req_if;
    logic valid;
    logic ready;
    bpa_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
    logic valid;
    logic ready;
    bpa_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpa_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [bpa_pkg::ADDR_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/bpa_datapath.sv =====
module bpa_datapath #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12,
    parameter int PW         = $clog2(MAX_PAGES + 1),
    parameter int BW         = (MAX_PAGES > 8) ? $clog2(MAX_PAGES / 8) : 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clr_we,
    input  logic i_clr_all,
    input  logic [BW-1:0] i_clr_idx,
    input  logic i_load,
    input  bpa_pkg::t_req i_req,
    input  logic [bpa_pkg::ADDR_W-1:0] i_mem_base,
    input  logic [PW-1:0] i_limit,
    input  logic i_rd_en,
    input  logic [BW-1:0] i_rd_idx,
    input  logic i_scan_bit,
    input  logic i_mark_bit,
    input  logic [PW-1:0] i_page,
    output logic o_page_used,
    output logic o_run_hit,
    output logic [PW-1:0] o_start,
    output logic o_mark_done,
    output logic o_byte_full,
    output logic o_byte_empty,
    output logic [bpa_pkg::STAT_W-1:0] o_free_status,
    output logic o_free_act,
    output logic [PW-1:0] o_free_start,
    output logic [bpa_pkg::ADDR_W-1:0] o_alloc_addr
);
    localparam int NB = MAX_PAGES / 8;

    logic [7:0] r_mem [NB];
    logic [7:0] r_rd;
    logic [PW-1:0] r_run, n_run;
    logic [PW-1:0] r_start, n_start;
    logic [bpa_pkg::COUNT_W-1:0] r_cnt;
    logic [bpa_pkg::ADDR_W-1:0] r_addr;
    logic [bpa_pkg::ADDR_W-1:0] off;
    logic [bpa_pkg::ADDR_W:0] fsum;
    logic [PW-1:0] end_pg;
    logic wr_en;
    logic [7:0] wr_byte;
    logic bitv;

    assign bitv = r_rd[i_page[2:0]];
    assign o_page_used = bitv;
    assign o_byte_full = (r_rd == bpa_pkg::BYTE_FULL);
    assign o_byte_empty = (r_rd == bpa_pkg::BYTE_EMPTY);
    assign o_start = n_start;
    assign end_pg = r_start + PW'(r_cnt);
    assign o_mark_done = (i_page + PW'(1) == end_pg);
    assign o_run_hit = !bitv && ({1'b0, r_run} + 1'b1 == (PW+1)'(r_cnt));

    always_comb begin
        n_run = r_run;
        n_start = r_start;
        if (i_scan_bit) begin
            if (bitv) begin
                n_run = '0;
            end else begin
                if (r_run == '0) n_start = i_page;
                n_run = r_run + PW'(1);
            end
        end
    end

    assign off = r_addr - i_mem_base;
    assign fsum = {1'b0, off >> PAGE_SHIFT} + (bpa_pkg::ADDR_W+1)'(r_cnt);
    always_comb begin
        o_free_status = bpa_pkg::ST_OK;
        o_free_act = 1'b0;
        if (r_addr != '0) begin
            if (r_addr[PAGE_SHIFT-1:0] != '0) o_free_status = bpa_pkg::ST_MISALIGNED;
            else if (r_addr < i_mem_base) o_free_status = bpa_pkg::ST_RANGE;
            else if (fsum > (bpa_pkg::ADDR_W+1)'(i_limit)) o_free_status = bpa_pkg::ST_RANGE;
            else o_free_act = (r_cnt != '0);
        end
    end
    assign o_free_start = PW'(off >> PAGE_SHIFT);
    assign o_alloc_addr = i_mem_base + (bpa_pkg::ADDR_W'(r_start) << PAGE_SHIFT);

    always_comb begin
        wr_byte = r_rd;
        wr_byte[i_page[2:0]] = i_mark_bit;
        if (i_clr_all) wr_byte = bpa_pkg::BYTE_EMPTY;
        wr_en = i_clr_we;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt <= i_req.count;
            r_addr <= i_req.addr;
            r_run <= '0;
            r_start <= '0;
        end else begin
            r_run <= n_run;
            r_start <= (i_clr_we && !i_scan_bit) ? r_start : n_start;
        end
        if (i_rd_en) r_rd <= r_mem[i_rd_idx];
        else if (wr_en) r_rd <= wr_byte;
        if (wr_en) r_mem[i_clr_idx] <= wr_byte;
    end

    logic unused;
    assign unused = i_rst_n ^ i_limit[0];
endmodule

// ===== rtl/core/bpa_ctrl.sv =====
module bpa_ctrl #(
    parameter int MAX_PAGES = 4096,
    parameter int PW        = $clog2(MAX_PAGES + 1),
    parameter int BW        = (MAX_PAGES > 8) ? $clog2(MAX_PAGES / 8) : 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  bpa_pkg::t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output bpa_pkg::t_rsp o_rsp,
    input  logic [PW-1:0] i_limit,
    output logic o_clr_we,
    output logic o_clr_all,
    output logic [BW-1:0] o_clr_idx,
    output logic o_load,
    output logic o_rd_en,
    output logic [BW-1:0] o_rd_idx,
    output logic o_scan_bit,
    output logic o_mark_bit,
    output logic [PW-1:0] o_page,
    input  logic i_page_used,
    input  logic i_run_hit,
    input  logic [PW-1:0] i_start,
    input  logic i_mark_done,
    input  logic i_byte_full,
    input  logic i_byte_empty,
    input  logic [bpa_pkg::STAT_W-1:0] i_free_status,
    input  logic i_free_act,
    input  logic [PW-1:0] i_free_start,
    input  logic [bpa_pkg::ADDR_W-1:0] i_alloc_addr
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_SRD, S_SBIT, S_MRD, S_MBIT, S_DONE
    } t_state;

    t_state r_state;
    logic [BW:0] r_cidx;
    logic [PW-1:0] r_page;
    logic r_op;
    logic r_mval;
    logic [bpa_pkg::COUNT_W-1:0] r_cnt;
    logic [PW-1:0] r_mend;
    logic r_rsp_valid;
    bpa_pkg::t_rsp r_rsp;
    bpa_pkg::t_rsp r_out;
    logic at_lim;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_out;
    assign o_page = r_page;
    assign o_load = o_req_ready && i_req_valid;
    assign o_clr_idx = (r_state == S_CLEAR) ? r_cidx[BW-1:0] : BW'(r_page >> 3);
    assign o_rd_en = (r_state == S_SRD) || (r_state == S_MRD);
    assign o_rd_idx = BW'(r_page >> 3);
    assign o_scan_bit = (r_state == S_SBIT);
    assign o_mark_bit = (r_state == S_MBIT) ? r_mval : 1'b0;
    assign o_clr_we = (r_state == S_CLEAR) || (r_state == S_MBIT);
    assign o_clr_all = (r_state == S_CLEAR);
    assign at_lim = (r_page >= i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cidx <= '0;
            r_rsp_valid <= 1'b0;
            r_page <= '0;
        end else begin
            if (r_rsp_valid && i_rsp_ready && r_state != S_DONE) r_rsp_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_cidx <= r_cidx + 1'b1;
                    if (r_cidx == (BW+1)'(MAX_PAGES / 8 - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_load) begin
                        r_op <= i_req.op;
                        r_cnt <= i_req.count;
                        r_page <= '0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (r_op == bpa_pkg::OP_ALLOC) begin
                        if (r_cnt == '0) begin
                            r_rsp <= '{bpa_pkg::ST_ZERO, '0};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end else begin
                        if (i_free_act) begin
                            r_page <= i_free_start;
                            r_mend <= i_free_start + PW'(r_cnt);
                            r_mval <= 1'b0;
                            r_rsp <= '{bpa_pkg::ST_OK, '0};
                            r_state <= S_MRD;
                        end else begin
                            r_rsp <= '{i_free_status, '0};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SRD: begin
                    if (at_lim) begin
                        r_rsp <= '{bpa_pkg::ST_NOSPACE, '0};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SBIT;
                    end
                end
                S_SBIT: begin
                    if (i_run_hit) begin
                        r_page <= i_start;
                        r_mend <= i_start + PW'(r_cnt);
                        r_mval <= 1'b1;
                        r_state <= S_MRD;
                    end else if (r_page[2:0] == 3'd7 || r_page + PW'(1) >= i_limit) begin
                        r_page <= r_page + PW'(1);
                        r_state <= S_SRD;
                    end else begin
                        r_page <= r_page + PW'(1);
                    end
                end
                S_MRD: r_state <= S_MBIT;
                S_MBIT: begin
                    if (r_page + PW'(1) == r_mend) begin
                        if (r_mval) r_rsp <= '{bpa_pkg::ST_OK, i_alloc_addr};
                        r_state <= S_DONE;
                    end else begin
                        r_page <= r_page + PW'(1);
                        if (r_page[2:0] == 3'd7) r_state <= S_MRD;
                    end
                end
                S_DONE: begin
                    if (!r_rsp_valid || i_rsp_ready) begin
                        r_rsp_valid <= 1'b1;
                        r_out <= r_rsp;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = i_page_used ^ i_mark_done ^ i_byte_full ^ i_byte_empty;
endmodule

// ===== rtl/core/bitmap_page_allocator.sv =====
// Flow, accept to response valid: a zero-count alloc or a null or rejected free goes
// from S_DISP straight to S_DONE. Free: each bitmap byte touched is read, then each page
// is cleared. Alloc: each byte is read and each page scanned until a run fits, then each
// byte is read and each page marked. One request at a time: the next is accepted once
// a response is issued; a waiting response stalls only completion.
// Reset: synchronous active low; a clearing pass zeroes the bitmap before any request.
`include "bitmap_page_allocator_macros.svh"
module bitmap_page_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_SHIFT = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bpa_req_if.sink i_req,
    bpa_rsp_if.source o_rsp,
    bpa_cfg_if.sink i_cfg
);
    localparam int PW = $clog2(MAX_PAGES + 1);
    localparam int BW = (MAX_PAGES > 8) ? $clog2(MAX_PAGES / 8) : 1;

    logic [bpa_pkg::ADDR_W-1:0] r_mem_base;
    logic [bpa_pkg::COUNT_W-1:0] r_total;
    logic [PW-1:0] limit;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base <= '0;
            r_total <= bpa_pkg::COUNT_W'(4096);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == bpa_pkg::REG_MEM_BASE) r_mem_base <= i_cfg.wdata;
            else r_total <= i_cfg.wdata[bpa_pkg::COUNT_W-1:0];
        end
    end
    assign limit = ({19'd0, r_total} > 32'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(r_total);

    logic clr_we, clr_all, load, rd_en, scan_bit, mark_bit, page_used, run_hit, mark_done;
    logic byte_full, byte_empty, free_act;
    logic [BW-1:0] clr_idx, rd_idx;
    logic [PW-1:0] page, start, free_start;
    logic [bpa_pkg::STAT_W-1:0] free_status;
    logic [bpa_pkg::ADDR_W-1:0] alloc_addr;

    bpa_ctrl #(.MAX_PAGES(MAX_PAGES), .PW(PW), .BW(BW)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_req_valid(i_req.valid), .o_req_ready(i_req.ready), .i_req(i_req.data),
        .o_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready), .o_rsp(o_rsp.data),
        .i_limit(limit), .o_clr_we(clr_we), .o_clr_all(clr_all), .o_clr_idx(clr_idx),
        .o_load(load),
        .o_rd_en(rd_en), .o_rd_idx(rd_idx), .o_scan_bit(scan_bit), .o_mark_bit(mark_bit),
        .o_page(page), .i_page_used(page_used), .i_run_hit(run_hit), .i_start(start),
        .i_mark_done(mark_done), .i_byte_full(byte_full), .i_byte_empty(byte_empty),
        .i_free_status(free_status), .i_free_act(free_act), .i_free_start(free_start),
        .i_alloc_addr(alloc_addr)
    );

    bpa_datapath #(.MAX_PAGES(MAX_PAGES), .PAGE_SHIFT(PAGE_SHIFT), .PW(PW), .BW(BW)) u_dp (
        .i_clk, .i_rst_n, .i_clr_we(clr_we), .i_clr_all(clr_all), .i_clr_idx(clr_idx),
        .i_load(load),
        .i_req(i_req.data), .i_mem_base(r_mem_base), .i_limit(limit), .i_rd_en(rd_en),
        .i_rd_idx(rd_idx), .i_scan_bit(scan_bit), .i_mark_bit(mark_bit), .i_page(page),
        .o_page_used(page_used), .o_run_hit(run_hit), .o_start(start),
        .o_mark_done(mark_done), .o_byte_full(byte_full), .o_byte_empty(byte_empty),
        .o_free_status(free_status), .o_free_act(free_act), .o_free_start(free_start),
        .o_alloc_addr(alloc_addr)
    );

    `BPA_ASSERT_IMPL(a_nospace_addr, i_clk, i_rst_n, o_rsp.valid && o_rsp.data.status != bpa_pkg::ST_OK, o_rsp.data.alloc_addr == '0)
    `BPA_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_rsp.valid, o_rsp.data.status <= bpa_pkg::ST_ZERO)
    `BPA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, o_rsp.valid && $stable(o_rsp.data))
endmodule

// ===== tb/tb.sv =====
module tb;
    localparam int MAX_PAGES  = 4096;
    localparam int PAGE_SHIFT = 12;

    typedef struct {
        int first;
        int pages;
    } t_block;

    logic i_clk;
    logic i_rst_n;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();
    bpa_cfg_if cfg_ch ();

    bitmap_page_allocator #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    bit              page_used [MAX_PAGES];
    logic [47:0]     cur_base;
    logic [12:0]     page_total;
    int              last_start;
    bpa_pkg::t_rsp   pending_rsp [$];
    t_block          live_blocks [$];
    bit              quiet;
    int              mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bpa_pkg::t_rsp predict_rsp(bpa_pkg::t_req r);
        bpa_pkg::t_rsp rsp;
        longint      limit;
        longint      run;
        longint      first;
        longint      p;
        bit          found;
        logic [47:0] offs;
        rsp.status     = bpa_pkg::ST_OK;
        rsp.alloc_addr = '0;
        limit = (page_total > MAX_PAGES) ? MAX_PAGES : page_total;
        if (r.op == bpa_pkg::OP_ALLOC) begin
            if (r.count == 0) begin
                rsp.status = bpa_pkg::ST_ZERO;
            end else begin
                run = 0;
                first = 0;
                found = 0;
                for (p = 0; p < limit; p++) begin
                    if (page_used[p]) begin
                        run = 0;
                    end else begin
                        if (run == 0) first = p;
                        run++;
                        if (run == r.count) begin
                            found = 1;
                            break;
                        end
                    end
                end
                if (found) begin
                    for (p = first; p < first + r.count; p++) page_used[p] = 1'b1;
                    rsp.alloc_addr = cur_base + (48'(first) << PAGE_SHIFT);
                    last_start = int'(first);
                end else begin
                    rsp.status = bpa_pkg::ST_NOSPACE;
                end
            end
        end else if (r.addr != 0) begin
            if (r.addr[PAGE_SHIFT-1:0] != 0) begin
                rsp.status = bpa_pkg::ST_MISALIGNED;
            end else if (r.addr < cur_base) begin
                rsp.status = bpa_pkg::ST_RANGE;
            end else begin
                offs = (r.addr - cur_base) >> PAGE_SHIFT;
                if (longint'(offs) + longint'(r.count) > limit) begin
                    rsp.status = bpa_pkg::ST_RANGE;
                end else begin
                    for (p = offs; p < longint'(offs) + r.count; p++) page_used[p] = 1'b0;
                end
            end
        end
        return rsp;
    endfunction

    task automatic send_req(logic op, logic [12:0] count, logic [47:0] addr);
        bpa_pkg::t_req r;
        bpa_pkg::t_rsp e;
        r.op    = op;
        r.count = count;
        r.addr  = addr;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        last_start = -1;
        e = predict_rsp(r);
        pending_rsp.push_back(e);
        if (op == bpa_pkg::OP_ALLOC && e.status == bpa_pkg::ST_OK)
            live_blocks.push_back('{first: last_start, pages: int'(count)});
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [47:0] val);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == bpa_pkg::REG_MEM_BASE) cur_base = val;
        else page_total = val[12:0];
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        bpa_pkg::t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected response status %0d alloc_addr %h",
                       rsp_ch.data.status, rsp_ch.data.alloc_addr);
                mismatches++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, rsp_ch.data.status);
                    mismatches++;
                end
                if (rsp_ch.data.alloc_addr !== e.alloc_addr) begin
                    $error("alloc_addr expected %h actual %h",
                           e.alloc_addr, rsp_ch.data.alloc_addr);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic test_alloc_edges();
        send_req(bpa_pkg::OP_ALLOC, 13'd0, 48'h0);
        send_req(bpa_pkg::OP_ALLOC, 13'd1, 48'h0);
        send_req(bpa_pkg::OP_ALLOC, 13'd4095, 48'h0);
        send_req(bpa_pkg::OP_ALLOC, 13'd1, 48'h0);
        send_req(bpa_pkg::OP_ALLOC, 13'd8191, 48'h0);
        send_req(bpa_pkg::OP_FREE, 13'd4095, 48'h1000);
        send_req(bpa_pkg::OP_FREE, 13'd5, 48'h0);
        send_req(bpa_pkg::OP_FREE, 13'd0, 48'h1000);
        send_req(bpa_pkg::OP_ALLOC, 13'd4096, 48'h0);
        live_blocks.delete();
    endtask

    task automatic test_free_edges();
        send_req(bpa_pkg::OP_FREE, 13'd1, 48'hFFFF_FFFF_FFFF);
        send_req(bpa_pkg::OP_FREE, 13'd1, 48'hFFFF_FFFF_F000);
        send_req(bpa_pkg::OP_FREE, 13'd8191, 48'h1000);
        send_req(bpa_pkg::OP_FREE, 13'd4094, 48'h2000);
    endtask

    task automatic test_config_edges();
        write_reg(bpa_pkg::REG_MEM_BASE, 48'hFFFF_FFFF_F000);
        send_req(bpa_pkg::OP_ALLOC, 13'd2, 48'h0);
        send_req(bpa_pkg::OP_FREE, 13'd3, 48'hFFFF_FFFF_F000);
        send_req(bpa_pkg::OP_FREE, 13'd1, 48'h1000);
        write_reg(bpa_pkg::REG_TOTAL_PAGES, 48'd8191);
        send_req(bpa_pkg::OP_ALLOC, 13'd4096, 48'h0);
        write_reg(bpa_pkg::REG_TOTAL_PAGES, 48'd0);
        send_req(bpa_pkg::OP_ALLOC, 13'd1, 48'h0);
        send_req(bpa_pkg::OP_FREE, 13'd1, 48'hFFFF_FFFF_F000);
        write_reg(bpa_pkg::REG_MEM_BASE, 48'h800);
        write_reg(bpa_pkg::REG_TOTAL_PAGES, 48'd4096);
        send_req(bpa_pkg::OP_FREE, 13'd4096, 48'h1000);
        live_blocks.delete();
    endtask

    task automatic random_phase(logic [47:0] base, logic [12:0] total, int n);
        int          k;
        int          sel;
        int          lim;
        t_block      b;
        logic [47:0] a;
        write_reg(bpa_pkg::REG_MEM_BASE, base);
        write_reg(bpa_pkg::REG_TOTAL_PAGES, {35'd0, total});
        lim = (total > MAX_PAGES) ? MAX_PAGES : total;
        if (lim < 1) lim = 1;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                if ($urandom_range(0, 9) == 0)
                    send_req(bpa_pkg::OP_ALLOC, 13'($urandom_range(1, lim)), 48'($urandom));
                else
                    send_req(bpa_pkg::OP_ALLOC, 13'($urandom_range(1, 16)), 48'($urandom));
            end else if (sel < 90 && live_blocks.size() != 0) begin
                sel = $urandom_range(0, live_blocks.size() - 1);
                b = live_blocks[sel];
                live_blocks.delete(sel);
                a = base + (48'(b.first) << PAGE_SHIFT);
                send_req(bpa_pkg::OP_FREE, 13'(b.pages), a);
            end else begin
                a = 48'({$urandom, $urandom});
                case ($urandom_range(0, 3))
                    0: a[PAGE_SHIFT-1:0] = '0;
                    1: a = base + (48'($urandom_range(0, lim)) << PAGE_SHIFT);
                    2: a = base - 48'h1000;
                    default: ;
                endcase
                send_req(1'($urandom), 13'($urandom), a);
            end
        end
    endtask

    task automatic test_random();
        int ph;
        for (ph = 0; ph < 8; ph++) begin
            random_phase(48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000,
                         13'($urandom_range(8, 512)), 70);
            if (ph == 3) drain();
        end
        random_phase(48'h0, 13'd4096, 40);
        random_phase(48'hFFFF_FFFF_F000, 13'd64, 40);
        random_phase(48'h0000_0000_0801, 13'd8191, 30);
    endtask

    task automatic test_quiet_tail();
        quiet = 1'b1;
        random_phase(48'h0001_0000_0000, 13'd128, 60);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.wdata <= '0;
        quiet      = 1'b0;
        mismatches = 0;
        cur_base   = '0;
        page_total = 13'd4096;
        foreach (page_used[i]) page_used[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alloc_edges();
        test_free_edges();
        test_config_edges();
        test_random();
        test_quiet_tail();
        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/bpa_datapath.sv
rtl/core/bpa_ctrl.sv
rtl/core/bitmap_page_allocator.sv
tb/tb.sv
